[src/sida_pkg.sv]
// Shared types, constants and helpers for the signed integer to decimal ASCII block
package sida_pkg;

    // Default value width
    localparam int VALUE_BITS_DEF = 32;

    // Character code width and codes
    localparam int          CHAR_W     = 6;
    localparam logic [5:0]  CHAR_ZERO  = 6'd48;
    localparam logic [5:0]  CHAR_MINUS = 6'd45;

    // Decimal digits needed for the largest magnitude, 2^(bits-1)
    function automatic int num_digits(input int bits);
        int d;
        d = ((bits - 1) * 30103) / 100000 + 1;
        return d;
    endfunction

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // take a new item
        logic shift;      // one double-dabble step
        logic put_sign;   // load minus sign into output register
        logic put_digit;  // load next digit into output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic conv_done;  // current shift step is the final one
        logic negative;   // item was negative
        logic last_digit; // next digit is the least significant
    } stat_t;

endpackage

[src/sida_datapath.sv]
// Datapath: magnitude shifter, BCD register, digit pointer and output register
module sida_datapath #(
    parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  sida_pkg::cmd_t                cmd,
    output sida_pkg::stat_t               stat,
    input  logic signed [VALUE_BITS-1:0]  number,
    output logic [sida_pkg::CHAR_W-1:0]   char_code,
    output logic                          is_last
);

    localparam int DIGITS = sida_pkg::num_digits(VALUE_BITS);
    localparam int IDX_W  = $clog2(DIGITS);
    localparam int DIG_W  = $clog2(DIGITS + 1);
    localparam int CNT_W  = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0]      mag_reg;
    logic [3:0]                 bcd_reg [DIGITS];
    logic [3:0]                 bcd_next [DIGITS];
    logic [3:0]                 adj [DIGITS];
    logic [CNT_W-1:0]           cnt_reg;
    logic [DIG_W-1:0]           ndig_reg;
    logic [DIG_W-1:0]           ndig_next;
    logic [IDX_W-1:0]           ptr_reg;
    logic                       neg_reg;
    logic [sida_pkg::CHAR_W-1:0] char_reg;
    logic                       last_reg;
    logic [VALUE_BITS-1:0]      mag_in;
    logic                       grow;
    logic [3:0]                 cur_digit;

    // Two's complement magnitude; the most negative value maps to 2^(n-1)
    assign mag_in = number[VALUE_BITS-1]
                  ? (~$unsigned(number) + {{(VALUE_BITS-1){1'b0}}, 1'b1})
                  : $unsigned(number);

    // Double-dabble step: add 3 to digits of 5 or more, then shift in one bit
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? (bcd_reg[i] + 4'd3) : bcd_reg[i];
        end
        bcd_next[0] = {adj[0][2:0], mag_reg[VALUE_BITS-1]};
        for (int i = 1; i < DIGITS; i++)
        begin
            bcd_next[i] = {adj[i][2:0], adj[i-1][3]};
        end
    end

    // Digit count grows by at most one per step
    always_comb
    begin
        grow = 1'b0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if ((ndig_reg == DIG_W'(i)) && (bcd_next[i] != 4'd0))
            begin
                grow = 1'b1;
            end
        end
        ndig_next = ndig_reg + DIG_W'(grow);
    end

    assign cur_digit = bcd_reg[ptr_reg];

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg  <= mag_in;
            neg_reg  <= number[VALUE_BITS-1];
            cnt_reg  <= CNT_W'(VALUE_BITS - 1);
            ndig_reg <= DIG_W'(1);
            for (int i = 0; i < DIGITS; i++)
            begin
                bcd_reg[i] <= 4'd0;
            end
        end
        else if (cmd.shift)
        begin
            mag_reg  <= {mag_reg[VALUE_BITS-2:0], 1'b0};
            cnt_reg  <= cnt_reg - CNT_W'(1);
            ndig_reg <= ndig_next;
            ptr_reg  <= IDX_W'(ndig_next - DIG_W'(1));
            for (int i = 0; i < DIGITS; i++)
            begin
                bcd_reg[i] <= bcd_next[i];
            end
        end
        else if (cmd.put_digit)
        begin
            ptr_reg <= ptr_reg - IDX_W'(1);
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.put_sign)
        begin
            char_reg <= sida_pkg::CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.put_digit)
        begin
            char_reg <= sida_pkg::CHAR_ZERO + {2'b00, cur_digit};
            last_reg <= (ptr_reg == IDX_W'(0));
        end
    end

    assign stat.conv_done  = (cnt_reg == CNT_W'(0));
    assign stat.negative   = neg_reg;
    assign stat.last_digit = (ptr_reg == IDX_W'(0));

    assign char_code = char_reg;
    assign is_last   = last_reg;

endmodule

[src/sida_ctrl.sv]
// Controller: sequences conversion and character output, owns output valid
module sida_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  sida_pkg::stat_t  stat,
    output sida_pkg::cmd_t   cmd
);

    sida_pkg::state_t state_reg;
    sida_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;

    // Output register can take a character this cycle
    assign slot_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sida_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sida_pkg::ST_CONV;
                end
            end
            sida_pkg::ST_CONV:
            begin
                if (stat.conv_done)
                begin
                    state_next = stat.negative ? sida_pkg::ST_SIGN : sida_pkg::ST_DIGIT;
                end
            end
            sida_pkg::ST_SIGN:
            begin
                if (slot_free)
                begin
                    state_next = sida_pkg::ST_DIGIT;
                end
            end
            sida_pkg::ST_DIGIT:
            begin
                if (slot_free && stat.last_digit)
                begin
                    state_next = sida_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sida_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and commands
    always_comb
    begin
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.shift     = 1'b0;
        cmd.put_sign  = 1'b0;
        cmd.put_digit = 1'b0;
        unique case (state_reg)
            sida_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            sida_pkg::ST_CONV:
            begin
                cmd.shift = 1'b1;
            end
            sida_pkg::ST_SIGN:
            begin
                cmd.put_sign = slot_free;
            end
            sida_pkg::ST_DIGIT:
            begin
                cmd.put_digit = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Output valid: set on a new character, cleared when taken
    always_comb
    begin
        if (cmd.put_sign || cmd.put_digit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sida_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // Only one command at a time
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.shift, cmd.put_sign, cmd.put_digit}))
        else $error("more than one datapath command");

    // Sign state is entered only for negative items
    a_sign_neg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sida_pkg::ST_SIGN) |-> stat.negative)
        else $error("sign emitted for non-negative item");

    // Accepted item starts conversion next cycle
    a_load_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == sida_pkg::ST_CONV))
        else $error("item accepted without conversion");

    // Final digit returns to idle with a character waiting
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.put_digit && stat.last_digit) |=>
        ((state_reg == sida_pkg::ST_IDLE) && out_valid_reg))
        else $error("final digit did not end the item");

endmodule

[src/signed_int_to_decimal_ascii.sv]
// Top level: signed integer to decimal ASCII text, one character per item out
//
//  Channel   Handshake                Payload
//  input     in_valid / in_ready      number (VALUE_BITS, signed)
//  output    out_valid / out_ready    char_code (6), is_last (1)
//
// An item takes VALUE_BITS double-dabble steps (one bit per cycle through the BCD
// register), then the sign, if negative, and the digits go to the output register
// one at a time, most significant digit first. The controller returns to idle to
// accept the next item only after the last character is registered.
// The output register lets the next item be accepted while the last character waits.
// Output stalls hold the controller in its sign or digit state; nothing is lost.
// Reset clears only the controller state and output valid.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [VALUE_BITS-1:0]  number,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sida_pkg::CHAR_W-1:0]   char_code,
    output logic                          is_last
);

    sida_pkg::cmd_t  cmd;
    sida_pkg::stat_t stat;

    sida_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sida_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .cmd       (cmd),
        .stat      (stat),
        .number    (number),
        .char_code (char_code),
        .is_last   (is_last)
    );

endmodule
